>>> rtl/deduplicating_work_ring_assert.svh
// Assertion shorthands shared by the ring RTL; each expects clk and rst_n in scope.
`ifndef DEDUPLICATING_WORK_RING_ASSERT_SVH
`define DEDUPLICATING_WORK_RING_ASSERT_SVH

// Same-cycle implication.
`define DWR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dwr_pkg.sv
package dwr_pkg;

  localparam int RING_DEPTH_DEF = 16;
  localparam int NUM_WORKS_DEF  = 64;

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 6;
  localparam int STAT_W  = 3;
  localparam int WSTATE_W = 2;
  localparam int COUNT_W = 5;

  // request codes
  localparam logic [FUNC_W-1:0] FN_ENQ = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CAN = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DEQ = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CMP = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOTQ  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd4;

  // work states
  localparam logic [WSTATE_W-1:0] WS_IDLE = 2'd0;
  localparam logic [WSTATE_W-1:0] WS_PEND = 2'd1;
  localparam logic [WSTATE_W-1:0] WS_RUN  = 2'd2;

  typedef struct packed {
    logic                queued;
    logic [WSTATE_W-1:0] wstate;
  } wt_entry_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [ID_W-1:0]     work;
    logic [WSTATE_W-1:0] wstate;
    logic                queued;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

>>> rtl/dwr_in_if.sv
interface dwr_in_if import dwr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   work_id;

  modport source(output valid, func, work_id, input ready);
  modport sink(input valid, func, work_id, output ready);
endinterface

>>> rtl/dwr_out_if.sv
interface dwr_out_if import dwr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [ID_W-1:0]     work_out;
  logic [WSTATE_W-1:0] work_state;
  logic                work_queued;
  logic [COUNT_W-1:0]  ring_count;

  modport source(output valid, status, work_out, work_state, work_queued, ring_count,
                 input ready);
  modport sink(input valid, status, work_out, work_state, work_queued, ring_count,
               output ready);
endinterface

>>> rtl/deduplicating_work_ring.sv
// Enqueue, dequeue, complete and a cancel of an unqueued work: the word is decided in the
// look-up state and its result registered; the next word is taken back in the idle state.
// Cancel of a queued work: the look-up state starts a walk whose result is registered at
// its end; the ring memory is walked one entry per cycle through its read port.
// The result register lets the next word in while a finished result waits to be taken.
// Reset (synchronous, active low) clears head, tail and fill, then sweeps the work table,
`include "deduplicating_work_ring_assert.svh"

// one entry per cycle, before the first word is taken.
module deduplicating_work_ring import dwr_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int NUM_WORKS  = NUM_WORKS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  dwr_in_if.sink  in_ch,
  dwr_out_if.source out_ch
);

  localparam int RW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int WIDX = (NUM_WORKS > 1) ? $clog2(NUM_WORKS) : 1;

  // controller states
  localparam logic [2:0] S_CLR  = 3'd0;  // work table clearing sweep
  localparam logic [2:0] S_IDLE = 3'd1;  // take a word, start reads
  localparam logic [2:0] S_LOOK = 3'd2;  // read data back: decide, write back
  localparam logic [2:0] S_WALK = 3'd3;  // cancel: search and close the gap
  localparam logic [2:0] S_OUT  = 3'd4;  // result waits for the output register

  // Ring index helpers; head + offset never exceeds twice the depth.
  function automatic logic [RW-1:0] ring_add(logic [RW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
    return RW'(s);
  endfunction

  function automatic logic [RW-1:0] ring_inc(logic [RW-1:0] a);
    return (a == RW'(RING_DEPTH - 1)) ? '0 : a + RW'(1);
  endfunction

  function automatic logic [RW-1:0] ring_dec(logic [RW-1:0] a);
    return (a == '0) ? RW'(RING_DEPTH - 1) : a - RW'(1);
  endfunction

  function automatic logic id_ok(logic [ID_W-1:0] v);
    return 32'(v) < 32'(NUM_WORKS);
  endfunction

  // Memories: ring of work ids, and per-work mark plus state.
  logic [ID_W-1:0] ring_mem [RING_DEPTH];
  wt_entry_t       wt_mem   [NUM_WORKS];
  logic [ID_W-1:0] ring_q;
  wt_entry_t       wt_q;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [RW-1:0]     head_r, head_nxt;
  logic [RW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic              found_r, found_nxt;
  logic [WIDX-1:0]   clr_r, clr_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [ID_W-1:0]   id_r;

  // result path
  logic out_valid_r;
  res_t out_res_r;
  res_t hold_r;
  res_t res_c;
  logic fin;
  logic slot_free;

  // memory ports
  logic            rw_en;
  logic [RW-1:0]   rw_addr;
  logic [ID_W-1:0] rw_data;
  logic [RW-1:0]   ring_raddr;
  logic            ww_en;
  logic [WIDX-1:0] ww_addr;
  wt_entry_t       ww_data;

  logic acc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  // Output register is free when empty or being drained this cycle.
  assign slot_free   = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    cur_nxt    = cur_r;
    found_nxt  = found_r;
    clr_nxt    = clr_r;
    fin        = 1'b0;
    res_c      = '0;
    rw_en      = 1'b0;
    rw_addr    = tail_r;
    rw_data    = id_r;
    ring_raddr = head_r;
    ww_en      = 1'b0;
    ww_addr    = WIDX'(id_r);
    ww_data    = wt_q;

    case (state_r)
      S_CLR: begin
        // Zero one work table entry per cycle.
        ww_en   = 1'b1;
        ww_addr = clr_r;
        ww_data = '0;
        clr_nxt = clr_r + WIDX'(1);
        if (clr_r == WIDX'(NUM_WORKS - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        // Head entry and the work's table entry are read at the accept edge.
        if (acc) state_nxt = S_LOOK;
      end

      S_LOOK: begin
        if (func_r == FN_DEQ) begin
          fin = 1'b1;
          if (fill_r == '0) begin
            res_c.status = STAT_EMPTY;
          end else begin
            // Pop the oldest work and mark it running.
            head_nxt     = ring_inc(head_r);
            fill_nxt     = fill_r - CW'(1);
            res_c.status = STAT_DONE;
            res_c.work   = ring_q;
            if (id_ok(ring_q)) begin
              ww_en          = 1'b1;
              ww_addr        = WIDX'(ring_q);
              ww_data.queued = 1'b0;
              ww_data.wstate = WS_RUN;
              res_c.wstate   = WS_RUN;
            end
          end
        end else if (!id_ok(id_r)) begin
          fin          = 1'b1;
          res_c.status = STAT_NOTQ;
          res_c.work   = id_r;
        end else begin
          case (func_r)
            FN_ENQ: begin
              fin          = 1'b1;
              res_c.work   = id_r;
              res_c.wstate = wt_q.wstate;
              res_c.queued = wt_q.queued;
              if (wt_q.queued) begin
                res_c.status = STAT_DUP;
              end else if (fill_r == CW'(RING_DEPTH)) begin
                res_c.status = STAT_FULL;
              end else begin
                // Append at the tail; an idle work turns pending.
                res_c.status   = STAT_DONE;
                ww_en          = 1'b1;
                ww_data.queued = 1'b1;
                ww_data.wstate = (wt_q.wstate == WS_IDLE) ? WS_PEND : wt_q.wstate;
                res_c.wstate   = ww_data.wstate;
                res_c.queued   = 1'b1;
                rw_en          = 1'b1;
                tail_nxt       = ring_inc(tail_r);
                fill_nxt       = fill_r + CW'(1);
              end
            end

            FN_CAN: begin
              if (!wt_q.queued) begin
                fin          = 1'b1;
                res_c.status = STAT_NOTQ;
                res_c.work   = id_r;
                res_c.wstate = wt_q.wstate;
              end else begin
                // Re-read the head entry and start the walk at position zero.
                state_nxt = S_WALK;
                cur_nxt   = '0;
                found_nxt = 1'b0;
              end
            end

            FN_CMP: begin
              fin            = 1'b1;
              ww_en          = 1'b1;
              ww_data.queued = wt_q.queued;
              ww_data.wstate = wt_q.queued ? WS_PEND : WS_IDLE;
              res_c.status   = STAT_DONE;
              res_c.work     = id_r;
              res_c.wstate   = ww_data.wstate;
              res_c.queued   = wt_q.queued;
            end

            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // ring_q holds position cur_r; prefetch the next position.
        ring_raddr = ring_add(head_r, cur_r + CW'(1));
        if (cur_r == fill_r) begin
          fin        = 1'b1;
          res_c.work = id_r;
          if (found_r) begin
            ww_en          = 1'b1;
            ww_data.queued = 1'b0;
            ww_data.wstate = (wt_q.wstate == WS_PEND) ? WS_IDLE : wt_q.wstate;
            tail_nxt       = ring_dec(tail_r);
            fill_nxt       = fill_r - CW'(1);
            res_c.status   = STAT_DONE;
            res_c.wstate   = ww_data.wstate;
          end else begin
            res_c.status = STAT_NOTQ;
            res_c.wstate = wt_q.wstate;
            res_c.queued = wt_q.queued;
          end
        end else begin
          if (found_r) begin
            // Close the gap: move this entry one slot toward the head.
            rw_en   = 1'b1;
            rw_addr = ring_add(head_r, cur_r - CW'(1));
            rw_data = ring_q;
          end else if (ring_q == id_r) begin
            found_nxt = 1'b1;
          end
          cur_nxt = cur_r + CW'(1);
        end
      end

      S_OUT: begin
        if (slot_free) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_c.count = COUNT_W'(fill_nxt);
    if (fin) state_nxt = slot_free ? S_IDLE : S_OUT;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      cur_r   <= '0;
      found_r <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      cur_r   <= cur_nxt;
      found_r <= found_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Latch the request word.
  always_ff @(posedge clk) begin
    if (acc) begin
      func_r <= in_ch.func;
      id_r   <= in_ch.work_id;
    end
  end

  // ring memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (rw_en) ring_mem[rw_addr] <= rw_data;
    ring_q <= ring_mem[ring_raddr];
  end

  // work table: read once per word, held through the walk
  always_ff @(posedge clk) begin
    if (ww_en) wt_mem[ww_addr] <= ww_data;
    if (acc) wt_q <= wt_mem[WIDX'(in_ch.work_id)];
  end

  // output register with a hold stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((fin || state_r == S_OUT) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && slot_free) begin
      out_res_r <= res_c;
    end else if (state_r == S_OUT && slot_free) begin
      out_res_r <= hold_r;
    end
    if (fin && !slot_free) hold_r <= res_c;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.work_out    = out_res_r.work;
  assign out_ch.work_state  = out_res_r.wstate;
  assign out_ch.work_queued = out_res_r.queued;
  assign out_ch.ring_count  = out_res_r.count;

  `DWR_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CW'(RING_DEPTH), "fill exceeds ring depth")
  `DWR_ASSERT_NOW(a_tail_track, 1'b1, tail_r == ring_add(head_r, fill_r), "tail out of step")
  `DWR_ASSERT_NOW(a_walk_bound, state_r == S_WALK, cur_r <= fill_r, "cancel walk overran")
  `DWR_ASSERT_NOW(a_hold_busy, state_r == S_OUT, out_valid_r, "held result with free slot")
  `DWR_ASSERT_NEXT(a_acc_look, acc, state_r == S_LOOK, "accepted word not looked up")

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import dwr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = RING_DEPTH_DEF;
  localparam int NUM_WORKS  = NUM_WORKS_DEF;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dwr_in_if  in_ch();
  dwr_out_if out_ch();

  deduplicating_work_ring DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the ring: slots, head/tail, fill count and per-work mark/state.
  logic [ID_W-1:0]     ring_copy   [RING_DEPTH];
  logic [IDX_W-1:0]    ring_head;
  logic [IDX_W-1:0]    ring_tail;
  logic [COUNT_W-1:0]  ring_fill;
  logic                work_marked [NUM_WORKS];
  logic [WSTATE_W-1:0] work_phase  [NUM_WORKS];

  // Answers owed by the block, oldest first.
  res_t answers_due[$];

  int err_count     = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.func    = FN_ENQ;
    in_ch.work_id = '0;
    out_ch.ready  = 1'b0;
    ring_head     = '0;
    ring_tail     = '0;
    ring_fill     = '0;
    for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;
    for (int i = 0; i < NUM_WORKS; i++) begin
      work_marked[i] = 1'b0;
      work_phase[i]  = WS_IDLE;
    end
  end

  // Work out the answer to one accepted request and advance the mirror.
  function automatic res_t ring_answer(input logic [FUNC_W-1:0] f,
                                       input logic [ID_W-1:0] id);
    res_t r;
    int   hit;
    int   pos;
    logic [ID_W-1:0] w;
    r        = '0;
    r.status = STAT_DONE;
    r.work   = id;
    case (f)
      FN_DEQ: begin
        if (ring_fill == 0) begin
          r.status = STAT_EMPTY;
          r.work   = '0;
        end else begin
          w              = ring_copy[ring_head];
          ring_head      = IDX_W'((ring_head + 1) % RING_DEPTH);
          ring_fill      = COUNT_W'(ring_fill - 1);
          work_marked[w] = 1'b0;
          work_phase[w]  = WS_RUN;
          r.work         = w;
        end
      end
      FN_ENQ: begin
        if (work_marked[id]) begin
          r.status = STAT_DUP;
        end else if (ring_fill >= RING_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          work_marked[id] = 1'b1;
          if (work_phase[id] == WS_IDLE) work_phase[id] = WS_PEND;
          ring_copy[ring_tail] = id;
          ring_tail = IDX_W'((ring_tail + 1) % RING_DEPTH);
          ring_fill = COUNT_W'(ring_fill + 1);
        end
      end
      FN_CAN: begin
        hit = -1;
        if (work_marked[id]) begin
          for (pos = 0; pos < ring_fill; pos++) begin
            if (ring_copy[IDX_W'((ring_head + pos) % RING_DEPTH)] == id) begin
              hit = pos;
              break;
            end
          end
        end
        if (hit < 0) begin
          r.status = STAT_NOTQ;
        end else begin
          // Close the gap: pull every later entry one slot toward the head.
          for (pos = hit; pos + 1 < ring_fill; pos++)
            ring_copy[IDX_W'((ring_head + pos) % RING_DEPTH)] =
              ring_copy[IDX_W'((ring_head + pos + 1) % RING_DEPTH)];
          ring_tail       = IDX_W'((ring_tail + RING_DEPTH - 1) % RING_DEPTH);
          ring_fill       = COUNT_W'(ring_fill - 1);
          work_marked[id] = 1'b0;
          if (work_phase[id] == WS_PEND) work_phase[id] = WS_IDLE;
        end
      end
      default: begin
        work_phase[id] = work_marked[id] ? WS_PEND : WS_IDLE;
      end
    endcase
    if (r.status != STAT_EMPTY) begin
      r.wstate = work_phase[r.work];
      r.queued = work_marked[r.work];
    end
    r.count = ring_fill;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Sample both channels at the rising edge: record each accepted request
  // word, then compare each accepted result word against the oldest answer.
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        answers_due.push_back(ring_answer(in_ch.func, in_ch.work_id));
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          err_count++;
          $display("%0t ns: unexpected result word, expected none, got status %0d work %0d",
                   $time, out_ch.status, out_ch.work_out);
        end else begin
          want = answers_due.pop_front();
          check_field("status",      8'(want.status), 8'(out_ch.status));
          check_field("work_out",    8'(want.work),   8'(out_ch.work_out));
          check_field("work_state",  8'(want.wstate), 8'(out_ch.work_state));
          check_field("work_queued", 8'(want.queued), 8'(out_ch.work_queued));
          check_field("ring_count",  8'(want.count),  8'(out_ch.ring_count));
        end
      end
    end
  end

  // Receiver: hold ready low through a requested hold-off, otherwise stall
  // at random with the current stall rate.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Send one request word. Call at a falling edge; returns at a falling edge
  // with valid still high, so back-to-back words keep valid up.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.work_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and hold the sender off until every owed answer has come back.
  task automatic drain_answers();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (answers_due.size() != 0);
  endtask

  // Hit the edges directly: empty ring, unqueued work, duplicate, full ring,
  // cancels at the middle, head and tail, and completion of a running work.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_word(FN_DEQ, 6'd0);
    send_word(FN_CAN, 6'd5);
    send_word(FN_CMP, 6'd9);
    send_word(FN_ENQ, 6'd0);
    send_word(FN_ENQ, 6'd63);
    send_word(FN_ENQ, 6'd0);
    for (int i = 1; i <= 14; i++) send_word(FN_ENQ, ID_W'(i));
    send_word(FN_ENQ, 6'd42);
    send_word(FN_CAN, 6'd7);
    send_word(FN_CAN, 6'd0);
    send_word(FN_CAN, 6'd14);
    send_word(FN_DEQ, 6'd33);
    send_word(FN_CMP, 6'd63);
    drain_answers();
  endtask

  // Random traffic; most requests aim at a small pool of works so that
  // duplicates, re-queues of running works and cancel hits are common.
  task automatic test_random(input int count, input int idle_pct, input int stall,
                             input int id_span, input int enq_pct);
    logic [FUNC_W-1:0] f;
    logic [ID_W-1:0]   id;
    int roll;
    int base;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < enq_pct)                           f = FN_ENQ;
      else if (roll < enq_pct + (100 - enq_pct) / 3) f = FN_CAN;
      else if ($urandom_range(1) == 1)               f = FN_DEQ;
      else                                           f = FN_CMP;
      if ($urandom_range(9) < 8) id = ID_W'($urandom_range(id_span - 1));
      else                       id = ID_W'($urandom_range(NUM_WORKS - 1));
      // Aim half the cancels at a live entry, anywhere in the ring.
      if (f == FN_CAN && ring_fill != 0 && $urandom_range(1) == 1)
        id = ring_copy[IDX_W'((ring_head + $urandom_range(ring_fill - 1)) % RING_DEPTH)];
      // Aim half the completions at a work that is actually running.
      if (f == FN_CMP && $urandom_range(1) == 1) begin
        base = $urandom_range(NUM_WORKS - 1);
        for (int k = 0; k < NUM_WORKS; k++) begin
          if (work_phase[ID_W'((base + k) % NUM_WORKS)] == WS_RUN) begin
            id = ID_W'((base + k) % NUM_WORKS);
            break;
          end
        end
      end
      send_word(f, id);
    end
    drain_answers();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  // words, so the block fills and stalls its input; then let it all drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_left = 150;
    @(negedge clk);
    for (int i = 0; i < 80; i++)
      send_word((i % 3 == 2) ? FN_DEQ : FN_ENQ, ID_W'($urandom_range(NUM_WORKS - 1)));
    drain_answers();
  endtask

  initial begin
    int waited;
    // Hold reset low; the block then sweeps its work table before it takes
    // the first word, which the handshake absorbs.
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(320, 0, 0, 24, 40);
    test_random(300, 84, 0, 64, 50);
    test_random(300, 0, 84, 24, 35);
    test_random(320, 6, 6, 20, 45);
    test_backpressure();

    // Wait out the owed answers with a bound, then wait on to catch any stray
    // result word before the verdict.
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    waited = 0;
    while (answers_due.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (answers_due.size() != 0) begin
      err_count++;
      $display("%0t ns: %0d expected result words never arrived", $time, answers_due.size());
    end
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> deduplicating_work_ring.f
+incdir+rtl
rtl/dwr_pkg.sv
rtl/dwr_in_if.sv
rtl/dwr_out_if.sv
rtl/deduplicating_work_ring.sv
tb/sv/testbench.sv
